// ===== src/mi3_pkg.sv =====
`default_nettype none
// ============================================================================
// mi3_pkg
// Shared widths, constants and types of the 3x3 matrix inverse unit.
// ============================================================================
package mi3_pkg;

   localparam int ELEM_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_ELEMS   = 9;

   localparam int PROD_W      = 2 * ELEM_WIDTH;
   localparam int COF_W       = PROD_W + 1;
   localparam int SPLIT_W     = ELEM_WIDTH + 1;
   localparam int PLO_W       = ELEM_WIDTH + SPLIT_W + 1;
   localparam int PHI_W       = ELEM_WIDTH + COF_W - SPLIT_W;
   localparam int DET_W       = 3 * ELEM_WIDTH + 3;
   localparam int QUO_W       = ELEM_WIDTH + 2;
   localparam int NUM_W       = COF_W + 2 * FRAC_BITS + 1;
   localparam int HI_W        = NUM_W - QUO_W;
   localparam int REM_W       = DET_W + 1;

   localparam int FRONT_LAT   = 5;
   localparam int DIV_LAT     = QUO_W + 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ELEM_WIDTH-1:0] MAX_ELEM = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic [ELEM_WIDTH-1:0] MIN_ELEM = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
   localparam logic [ELEM_WIDTH-1:0] ONE_ELEM =
      (FRAC_BITS <= ELEM_WIDTH - 2) ? (ELEM_WIDTH'(1) << FRAC_BITS) : MAX_ELEM;

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef elem_type [NUM_ELEMS-1:0] mat_type;
   typedef logic [COF_W-1:0] cof_type;

   typedef struct packed {
      cof_type [NUM_ELEMS-1:0] cof;
      logic [DET_W-1:0]        det;
   } front_res_type;

   typedef struct packed {
      mat_type elem;
      logic    singular;
   } inv_res_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage
`default_nettype wire

// ===== src/mi3_front.sv =====
`default_nettype none
// ============================================================================
// mi3_front
// Takes matrices in and forms the nine adjugate entries and the determinant.
// ============================================================================
module mi3_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  mi3_pkg::mat_type       mat,
   input  mi3_pkg::queue_stat_type q_stat,
   output logic                   q_push,
   output mi3_pkg::front_res_type q_data
);
   import mi3_pkg::*;

   localparam int unsigned SEL [NUM_ELEMS][4] = '{
      '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 8, 3}, '{8, 0, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 1, 3}};
   localparam int unsigned DET_COF [3] = '{0, 3, 6};

   logic                    en;
   logic [FRONT_LAT-1:0]    v_ff, v_in;

   logic signed [PROD_W-1:0] prod_ff [NUM_ELEMS][2];
   logic signed [PROD_W-1:0] prod_in [NUM_ELEMS][2];
   elem_type                 row1_ff [3], row1_in [3];
   cof_type                  cof2_ff [NUM_ELEMS], cof2_in [NUM_ELEMS];
   elem_type                 row2_ff [3], row2_in [3];
   logic signed [PLO_W-1:0]  plo_ff [3], plo_in [3];
   logic signed [PHI_W-1:0]  phi_ff [3], phi_in [3];
   cof_type                  cof3_ff [NUM_ELEMS], cof3_in [NUM_ELEMS];
   logic [DET_W-1:0]         term_ff [3], term_in [3];
   cof_type                  cof4_ff [NUM_ELEMS], cof4_in [NUM_ELEMS];
   front_res_type            out_ff, out_in;

   assign en     = !(v_ff[FRONT_LAT-1] && q_stat.full);
   assign full   = !en;
   assign q_push = v_ff[FRONT_LAT-1] && !q_stat.full;
   assign q_data = out_ff;

   always_comb begin
      v_in = {v_ff[FRONT_LAT-2:0], push};
      for (int i = 0; i < NUM_ELEMS; i++) begin
         prod_in[i][0] = $signed(mat[SEL[i][0]]) * $signed(mat[SEL[i][1]]);
         prod_in[i][1] = $signed(mat[SEL[i][2]]) * $signed(mat[SEL[i][3]]);
         cof2_in[i] = {prod_ff[i][0][PROD_W-1], prod_ff[i][0]}
                    - {prod_ff[i][1][PROD_W-1], prod_ff[i][1]};
         cof3_in[i] = cof2_ff[i];
         cof4_in[i] = cof3_ff[i];
         out_in.cof[i] = cof4_ff[i];
      end
      for (int k = 0; k < 3; k++) begin
         row1_in[k] = mat[k];
         row2_in[k] = row1_ff[k];
         phi_in[k]  = $signed(row2_ff[k])
                    * $signed(cof2_ff[DET_COF[k]][COF_W-1:SPLIT_W]);
         plo_in[k]  = $signed(row2_ff[k])
                    * $signed({1'b0, cof2_ff[DET_COF[k]][SPLIT_W-1:0]});
         term_in[k] = {{(DET_W-PHI_W-SPLIT_W){phi_ff[k][PHI_W-1]}}, phi_ff[k],
                       {SPLIT_W{1'b0}}}
                    + {{(DET_W-PLO_W){plo_ff[k][PLO_W-1]}}, plo_ff[k]};
      end
      out_in.det = term_ff[0] + term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         row1_ff <= row1_in;
         cof2_ff <= cof2_in;
         row2_ff <= row2_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         cof3_ff <= cof3_in;
         term_ff <= term_in;
         cof4_ff <= cof4_in;
         out_ff  <= out_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/mi3_queue.sv =====
`default_nettype none
// ============================================================================
// mi3_queue
// Short queue between the cofactor front end and the divider back end.
// ============================================================================
module mi3_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mi3_pkg::front_res_type  push_data,
   input  logic                    pop,
   output mi3_pkg::front_res_type  pop_data,
   output mi3_pkg::queue_stat_type stat
);
   import mi3_pkg::*;

   front_res_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== src/mi3_div.sv =====
`default_nettype none
// ============================================================================
// mi3_div
// Pipelined restoring divider for one inverse element, one quotient bit per
// stage, with round to nearest and saturation at the end.
// ============================================================================
module mi3_div (
   input  logic                       clock,
   input  logic                       en,
   input  mi3_pkg::cof_type           cof,
   input  logic [mi3_pkg::DET_W-1:0]  det,
   output mi3_pkg::elem_type          quo
);
   import mi3_pkg::*;

   logic             neg0_ff, neg0_in;
   logic [COF_W-1:0] cmag_ff, cmag_in;
   logic [DET_W-1:0] dmag_ff, dmag_in;
   logic [NUM_W-1:0] num;

   logic [REM_W-1:0] rem_ff [QUO_W+1], rem_in [QUO_W+1];
   logic [QUO_W-1:0] low_ff [QUO_W+1], low_in [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1], q_in   [QUO_W+1];
   logic [DET_W-1:0] dv_ff  [QUO_W+1], dv_in  [QUO_W+1];
   logic             neg_ff [QUO_W+1], neg_in [QUO_W+1];
   logic             ovf_ff [QUO_W+1], ovf_in [QUO_W+1];
   logic [REM_W-1:0] shifted [QUO_W];
   logic             ge [QUO_W];

   logic [QUO_W:0]   rnd;
   logic [QUO_W-1:0] mag;
   elem_type         out_ff, out_in;

   assign quo = out_ff;

   always_comb begin
      cmag_in = cof[COF_W-1] ? (~cof + 1'b1) : cof;
      dmag_in = det[DET_W-1] ? (~det + 1'b1) : det;
      neg0_in = cof[COF_W-1] ^ det[DET_W-1];

      num       = {cmag_ff, {(2*FRAC_BITS+1){1'b0}}};
      rem_in[0] = {{(REM_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
      low_in[0] = num[QUO_W-1:0];
      q_in[0]   = '0;
      dv_in[0]  = dmag_ff;
      neg_in[0] = neg0_ff;
      ovf_in[0] = {{(REM_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]} >= {1'b0, dmag_ff};

      for (int k = 0; k < QUO_W; k++) begin
         shifted[k]  = {rem_ff[k][REM_W-2:0], low_ff[k][QUO_W-1]};
         ge[k]       = shifted[k] >= {1'b0, dv_ff[k]};
         rem_in[k+1] = ge[k] ? (shifted[k] - {1'b0, dv_ff[k]}) : shifted[k];
         low_in[k+1] = {low_ff[k][QUO_W-2:0], 1'b0};
         q_in[k+1]   = {q_ff[k][QUO_W-2:0], ge[k]};
         dv_in[k+1]  = dv_ff[k];
         neg_in[k+1] = neg_ff[k];
         ovf_in[k+1] = ovf_ff[k];
      end

      rnd = {1'b0, q_ff[QUO_W]} + 1'b1;
      mag = rnd[QUO_W:1];
      if (ovf_ff[QUO_W]) begin
         out_in = neg_ff[QUO_W] ? MIN_ELEM : MAX_ELEM;
      end else if (neg_ff[QUO_W]) begin
         out_in = (mag > {{(QUO_W-ELEM_WIDTH){1'b0}}, MIN_ELEM})
                ? MIN_ELEM : (~mag[ELEM_WIDTH-1:0] + 1'b1);
      end else begin
         out_in = (mag > {{(QUO_W-ELEM_WIDTH){1'b0}}, MAX_ELEM})
                ? MAX_ELEM : mag[ELEM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmag_ff <= cmag_in;
         dmag_ff <= dmag_in;
         neg0_ff <= neg0_in;
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         q_ff    <= q_in;
         dv_ff   <= dv_in;
         neg_ff  <= neg_in;
         ovf_ff  <= ovf_in;
         out_ff  <= out_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/mi3_back.sv =====
`default_nettype none
// ============================================================================
// mi3_back
// Divides the adjugate by the determinant in nine divider lanes, substitutes
// the identity for a singular matrix and holds results in an output queue.
// ============================================================================
module mi3_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mi3_pkg::queue_stat_type q_stat,
   input  mi3_pkg::front_res_type  q_data,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output mi3_pkg::inv_res_type    res
);
   import mi3_pkg::*;

   logic               en;
   logic [DIV_LAT-1:0] v_ff, v_in;
   logic [DIV_LAT-1:0] sing_ff, sing_in;
   mat_type            quo;
   inv_res_type        res_in;

   inv_res_type        oq_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               oq_full, oq_push, oq_pop;

   assign oq_full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign en      = !(v_ff[DIV_LAT-1] && oq_full);
   assign q_pop   = en && !q_stat.empty;
   assign oq_push = v_ff[DIV_LAT-1] && !oq_full;
   assign oq_pop  = pop && !empty;
   assign res     = oq_ff[rd_ff];

   for (genvar i = 0; i < NUM_ELEMS; i++) begin : g_lane
      mi3_div u_div (
         .clock (clock),
         .en    (en),
         .cof   (q_data.cof[i]),
         .det   (q_data.det),
         .quo   (quo[i])
      );
      assign res_in.elem[i] = sing_ff[DIV_LAT-1] ? ((i % 4 == 0) ? ONE_ELEM : '0) : quo[i];
   end
   assign res_in.singular = sing_ff[DIV_LAT-1];

   always_comb begin
      v_in    = {v_ff[DIV_LAT-2:0], q_pop};
      sing_in = {sing_ff[DIV_LAT-2:0], (q_data.det == '0)};
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff + QCNT_W'(oq_push) - QCNT_W'(oq_pop);
      if (oq_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (oq_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (en) begin
            v_ff <= v_in;
         end
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= sing_in;
      end
      if (oq_push) begin
         oq_ff[wr_ff] <= res_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/matrix3x3_inverse_unit.sv =====
`default_nettype none
// ============================================================================
// matrix3x3_inverse_unit
// Inverse of a signed Q16.16 3x3 matrix by adjugate over determinant.
// ============================================================================
// Usage: a matrix word is written with push while full is low; results are
// read like a queue, the oldest word on the rsp_ ports while empty is low,
// taken with pop. A singular matrix returns the identity with rsp_singular set.
// Results leave in the order the matrices arrived.
// Path from the accepting edge to empty going low: the front end of 5 stages,
// the middle queue register, 37 divider stages and the output queue.
// The divider length follows from one quotient bit per stage over 34 bits.
// Throughput: one matrix per cycle, sustained as long as results are popped.
// When the receiver stalls, the output queue fills, the divider pipeline
// freezes, the middle queue fills, and then the front end freezes and full
// rises; no word is lost. Reset empties both queues and all pipeline valids.
// ============================================================================
module matrix3x3_inverse_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  mi3_pkg::elem_type   req_m00,
   input  mi3_pkg::elem_type   req_m01,
   input  mi3_pkg::elem_type   req_m02,
   input  mi3_pkg::elem_type   req_m10,
   input  mi3_pkg::elem_type   req_m11,
   input  mi3_pkg::elem_type   req_m12,
   input  mi3_pkg::elem_type   req_m20,
   input  mi3_pkg::elem_type   req_m21,
   input  mi3_pkg::elem_type   req_m22,
   output logic                empty,
   input  logic                pop,
   output mi3_pkg::elem_type   rsp_r00,
   output mi3_pkg::elem_type   rsp_r01,
   output mi3_pkg::elem_type   rsp_r02,
   output mi3_pkg::elem_type   rsp_r10,
   output mi3_pkg::elem_type   rsp_r11,
   output mi3_pkg::elem_type   rsp_r12,
   output mi3_pkg::elem_type   rsp_r20,
   output mi3_pkg::elem_type   rsp_r21,
   output mi3_pkg::elem_type   rsp_r22,
   output logic                rsp_singular
);
   import mi3_pkg::*;

   mat_type        mat;
   front_res_type  f_data, b_data;
   queue_stat_type q_stat;
   logic           f_push, b_pop;
   inv_res_type    res;

   assign mat = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
                 req_m02, req_m01, req_m00};

   mi3_front u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .full   (full),
      .mat    (mat),
      .q_stat (q_stat),
      .q_push (f_push),
      .q_data (f_data)
   );

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_data),
      .pop       (b_pop),
      .pop_data  (b_data),
      .stat      (q_stat)
   );

   mi3_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .q_data (b_data),
      .q_pop  (b_pop),
      .empty  (empty),
      .pop    (pop),
      .res    (res)
   );

   assign rsp_r00      = res.elem[0];
   assign rsp_r01      = res.elem[1];
   assign rsp_r02      = res.elem[2];
   assign rsp_r10      = res.elem[3];
   assign rsp_r11      = res.elem[4];
   assign rsp_r12      = res.elem[5];
   assign rsp_r20      = res.elem[6];
   assign rsp_r21      = res.elem[7];
   assign rsp_r22      = res.elem[8];
   assign rsp_singular = res.singular;

endmodule
`default_nettype wire

// ===== src/mi3_checker.sv =====
`default_nettype none
// ============================================================================
// mi3_checker
// Port-level checks of the matrix inverse unit, bound to the top level.
// ============================================================================
module mi3_checker (
   input logic              clock,
   input logic              reset,
   input logic              push,
   input logic              full,
   input mi3_pkg::elem_type req_m00,
   input mi3_pkg::elem_type req_m01,
   input mi3_pkg::elem_type req_m02,
   input mi3_pkg::elem_type req_m10,
   input mi3_pkg::elem_type req_m11,
   input mi3_pkg::elem_type req_m12,
   input mi3_pkg::elem_type req_m20,
   input mi3_pkg::elem_type req_m21,
   input mi3_pkg::elem_type req_m22,
   input logic              empty,
   input logic              pop,
   input mi3_pkg::elem_type rsp_r00,
   input mi3_pkg::elem_type rsp_r01,
   input mi3_pkg::elem_type rsp_r02,
   input mi3_pkg::elem_type rsp_r10,
   input mi3_pkg::elem_type rsp_r11,
   input mi3_pkg::elem_type rsp_r12,
   input mi3_pkg::elem_type rsp_r20,
   input mi3_pkg::elem_type rsp_r21,
   input mi3_pkg::elem_type rsp_r22,
   input logic              rsp_singular
);
   import mi3_pkg::*;

   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_ready : assert property (@(posedge clock) reset |=> !full)
      else $error("input side not ready after reset");

   a_singular_identity : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_singular) |->
         (rsp_r00 == ONE_ELEM && rsp_r11 == ONE_ELEM && rsp_r22 == ONE_ELEM &&
          rsp_r01 == '0 && rsp_r02 == '0 && rsp_r10 == '0 &&
          rsp_r12 == '0 && rsp_r20 == '0 && rsp_r21 == '0))
      else $error("singular result is not the identity");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_r00) && $stable(rsp_r22) &&
                            $stable(rsp_singular)))
      else $error("waiting result changed while stalled");

endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (.*);
`default_nettype wire

// ===== dv/matrix3x3_inverse_checker.sv =====
// ============================================================================
// matrix3x3_inverse_checker
// Watches both queue ports of the matrix inverse unit and predicts every
// result word from the accepted matrix with exact wide integer arithmetic.
// Each popped word is compared field by field with the oldest prediction.
// ============================================================================
module matrix3x3_inverse_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  mi3_pkg::mat_type  req_mat,
   input  logic              empty,
   input  logic              pop,
   input  mi3_pkg::mat_type  rsp_mat,
   input  logic              rsp_singular,
   output int                fail_count,
   output int                pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import mi3_pkg::*;

   typedef logic signed [255:0] wide_type;

   inv_res_type inverse_queue[$];

   function automatic elem_type divide_round_sat(wide_type cof, wide_type det);
      wide_type num, den, quo, rem, lim;
      logic neg;
      num = cof <<< (2 * FRAC_BITS);
      neg = 1'b0;
      if (num < 0) begin
         num = -num;
         neg = ~neg;
      end
      den = det;
      if (den < 0) begin
         den = -den;
         neg = ~neg;
      end
      quo = num / den;
      rem = num % den;
      if (2 * rem >= den) begin
         quo = quo + 1;
      end
      lim = wide_type'(1) <<< (ELEM_WIDTH - 1);
      if (neg) begin
         if (quo > lim) begin
            quo = lim;
         end
         quo = -quo;
      end else if (quo > lim - 1) begin
         quo = lim - 1;
      end
      return quo[ELEM_WIDTH-1:0];
   endfunction

   function automatic inv_res_type predict_inverse(mat_type mat);
      wide_type m[9];
      wide_type c[9];
      wide_type det;
      inv_res_type res;
      for (int i = 0; i < 9; i++) begin
         m[i] = wide_type'(signed'(mat[i]));
      end
      c[0] = m[4] * m[8] - m[7] * m[5];
      c[1] = m[7] * m[2] - m[1] * m[8];
      c[2] = m[1] * m[5] - m[2] * m[4];
      c[3] = m[5] * m[6] - m[8] * m[3];
      c[4] = m[8] * m[0] - m[2] * m[6];
      c[5] = m[2] * m[3] - m[0] * m[5];
      c[6] = m[3] * m[7] - m[6] * m[4];
      c[7] = m[6] * m[1] - m[0] * m[7];
      c[8] = m[0] * m[4] - m[1] * m[3];
      det = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
      if (det == 0) begin
         for (int i = 0; i < 9; i++) begin
            res.elem[i] = (i % 4 == 0) ? ONE_ELEM : '0;
         end
         res.singular = 1'b1;
      end else begin
         for (int i = 0; i < 9; i++) begin
            res.elem[i] = divide_round_sat(c[i], det);
         end
         res.singular = 1'b0;
      end
      return res;
   endfunction

   assign pending_count = inverse_queue.size();

   always @(posedge clock) begin
      inv_res_type exp_word;
      if (reset) begin
         fail_count <= 0;
         inverse_queue.delete();
      end else begin
         if (push && !full) begin
            inverse_queue.insert(inverse_queue.size(), predict_inverse(req_mat));
         end
         if (pop && !empty) begin
            if (inverse_queue.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result word at %0t", $realtime);
               end
               fail_count <= fail_count + 1;
            end else begin
               exp_word = inverse_queue.pop_front();
               if (exp_word.elem !== rsp_mat || exp_word.singular !== rsp_singular) begin
                  if (fail_count < 10) begin
                     for (int i = 0; i < 9; i++) begin
                        if (exp_word.elem[i] !== rsp_mat[i]) begin
                           $display("element %0d: expected %h, got %h",
                                    i, exp_word.elem[i], rsp_mat[i]);
                        end
                     end
                     $display("singular: expected %b, got %b at %0t",
                              exp_word.singular, rsp_singular, $realtime);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== dv/tb_matrix3x3_inverse_unit.sv =====
// ============================================================================
// tb_matrix3x3_inverse_unit
// Drives directed and random matrices into the matrix inverse unit under
// several idle and stall mixes; the checker predicts and compares results.
// ============================================================================
module tb_matrix3x3_inverse_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mi3_pkg::*;

   logic     clock;
   logic     reset;
   logic     push;
   logic     full;
   mat_type  req_mat;
   logic     empty;
   logic     pop;
   mat_type  rsp_mat;
   logic     rsp_singular;
   int       fail_count;
   int       pending_count;
   int       cycle_count;
   int       send_idle_pct;
   int       pop_stall_pct;

   matrix3x3_inverse_unit dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_m00(req_mat[0]), .req_m01(req_mat[1]), .req_m02(req_mat[2]),
      .req_m10(req_mat[3]), .req_m11(req_mat[4]), .req_m12(req_mat[5]),
      .req_m20(req_mat[6]), .req_m21(req_mat[7]), .req_m22(req_mat[8]),
      .empty(empty), .pop(pop),
      .rsp_r00(rsp_mat[0]), .rsp_r01(rsp_mat[1]), .rsp_r02(rsp_mat[2]),
      .rsp_r10(rsp_mat[3]), .rsp_r11(rsp_mat[4]), .rsp_r12(rsp_mat[5]),
      .rsp_r20(rsp_mat[6]), .rsp_r21(rsp_mat[7]), .rsp_r22(rsp_mat[8]),
      .rsp_singular(rsp_singular)
   );

   matrix3x3_inverse_checker checker_inst (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_mat(req_mat),
      .empty(empty), .pop(pop), .rsp_mat(rsp_mat), .rsp_singular(rsp_singular),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      pop <= ($urandom_range(99) >= pop_stall_pct);
      if (cycle_count > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic elem_type random_elem();
      case ($urandom_range(7))
         0: return elem_type'($urandom_range(2)) << FRAC_BITS;
         1: return -(elem_type'($urandom_range(3)) << FRAC_BITS);
         2: return $urandom_range(1) ? MAX_ELEM : MIN_ELEM;
         3: return elem_type'($urandom_range(255));
         4: return elem_type'(signed'($urandom_range(4096)) - 2048) << 12;
         default: return $urandom;
      endcase
   endfunction

   // Leaves push high on return; the caller drops it when the stream pauses.
   task automatic send_matrix(mat_type mat);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_mat <= mat;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random(int count);
      mat_type mat;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++) begin
            mat[i] = random_elem();
         end
         if ($urandom_range(9) == 0) begin
            for (int i = 0; i < 3; i++) begin
               mat[6 + i] = mat[3 + i];
            end
         end
         send_matrix(mat);
      end
   endtask

   initial begin
      mat_type mat;
      cycle_count = 0;
      push = 1'b0;
      pop = 1'b0;
      req_mat = '0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      mat = '0;
      send_matrix(mat);
      mat[0] = ONE_ELEM; mat[4] = ONE_ELEM; mat[8] = ONE_ELEM;
      send_matrix(mat);
      mat[0] = 1; mat[4] = 1; mat[8] = 1;
      send_matrix(mat);
      mat[0] = MAX_ELEM; mat[4] = MAX_ELEM; mat[8] = MAX_ELEM;
      send_matrix(mat);
      mat[0] = MIN_ELEM; mat[4] = MIN_ELEM; mat[8] = MIN_ELEM;
      send_matrix(mat);
      mat[0] = MIN_ELEM; mat[4] = MAX_ELEM; mat[8] = 1;
      send_matrix(mat);
      for (int i = 0; i < 9; i++) begin
         mat[i] = MIN_ELEM;
      end
      send_matrix(mat);
      for (int i = 0; i < 9; i++) begin
         mat[i] = '1;
      end
      send_matrix(mat);
      for (int i = 0; i < 9; i++) begin
         mat[i] = elem_type'(i + 1) << FRAC_BITS;
      end
      send_matrix(mat);
      mat[8] = elem_type'(10) << FRAC_BITS;
      send_matrix(mat);
      mat = '0;
      mat[2] = 3; mat[4] = 2; mat[6] = 1;
      send_matrix(mat);
      mat = '0;
      mat[0] = ONE_ELEM; mat[4] = ONE_ELEM; mat[8] = 3 << FRAC_BITS;
      send_matrix(mat);

      send_random(450);
      send_idle_pct = 65;
      send_random(400);
      push <= 1'b0;
      while (pending_count != 0) begin
         @(posedge clock);
      end
      send_idle_pct = 0;
      pop_stall_pct = 65;
      send_random(450);
      send_idle_pct = 34;
      pop_stall_pct = 34;
      send_random(440);
      push <= 1'b0;

      while (pending_count != 0 && cycle_count < 390000) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
